/* hdl/hcb_pkg.sv */
// Huffman code builder: shared widths, item kinds, list entry and chain command types.
// No dependencies; every other file depends on this package.
`default_nettype none
package hcb_pkg;

  localparam int NUM_SYMBOLS = 256;
  localparam int SYM_W       = 8;
  localparam int KIND_W      = 2;
  localparam int CNT_W       = 32;
  localparam int NCNT_W      = 40;
  localparam int ID_W        = 9;
  localparam int LEN_W       = 6;
  localparam int BITS_W      = 63;
  localparam int LIST_W      = $clog2(NUM_SYMBOLS + 1);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(63);

  localparam logic [KIND_W-1:0] KIND_COUNT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INS    = 2'd1;
  localparam logic [1:0] OP_SHIFT2 = 2'd2;
  localparam logic [1:0] OP_CLR    = 2'd3;

  typedef struct packed {
    logic              vld;
    logic [NCNT_W-1:0] cnt;
    logic [ID_W-1:0]   id;
  } ent_t;

  typedef struct packed {
    logic [1:0] op;
    ent_t       item;
  } chain_cmd_t;

endpackage
`default_nettype wire

/* hdl/hcb_in_if.sv */
// Input channel of the Huffman code builder: valid/ready plus item payload.
// Depends on hcb_pkg for field widths.
`default_nettype none
interface hcb_in_if;
  logic                        valid;
  logic                        ready;
  logic [hcb_pkg::KIND_W-1:0]  kind;
  logic [hcb_pkg::SYM_W-1:0]   data_byte;
  logic [hcb_pkg::SYM_W-1:0]   query_symbol;

  modport source (output valid, kind, data_byte, query_symbol, input ready);
  modport sink   (input valid, kind, data_byte, query_symbol, output ready);
endinterface
`default_nettype wire

/* hdl/hcb_out_if.sv */
// Result channel of the Huffman code builder: valid/ready plus result payload.
// Depends on hcb_pkg for field widths.
`default_nettype none
interface hcb_out_if;
  logic                        valid;
  logic                        ready;
  logic [hcb_pkg::SYM_W-1:0]   symbol;
  logic [hcb_pkg::CNT_W-1:0]   symbol_count;
  logic [hcb_pkg::LEN_W-1:0]   code_length;
  logic [hcb_pkg::BITS_W-1:0]  code_bits;
  logic                        build_done;

  modport source (output valid, symbol, symbol_count, code_length, code_bits, build_done,
                  input ready);
  modport sink   (input valid, symbol, symbol_count, code_length, code_bits, build_done,
                  output ready);
endinterface
`default_nettype wire

/* hdl/hcb_cell.sv */
// One slot of the sorted node list: holds an entry, inserts, shifts or clears per command.
// Depends on hcb_pkg.
`default_nettype none
module hcb_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  hcb_pkg::chain_cmd_t cmd,
  input  hcb_pkg::ent_t       left,
  input  hcb_pkg::ent_t       right2,
  input  logic                take_in,
  output logic                take_out,
  output hcb_pkg::ent_t       q
);
  import hcb_pkg::*;

  logic              vld_r, vld_nxt;
  logic [NCNT_W-1:0] cnt_r, cnt_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;

  // this slot or an earlier one is where the new entry lands
  assign take_out = !vld_r || (cnt_r > cmd.item.cnt);

  always_comb begin
    vld_nxt = vld_r;
    cnt_nxt = cnt_r;
    id_nxt  = id_r;
    unique case (cmd.op)
      OP_INS: begin
        if (take_in) begin
          vld_nxt = left.vld;
          cnt_nxt = left.cnt;
          id_nxt  = left.id;
        end else if (take_out) begin
          vld_nxt = 1'b1;
          cnt_nxt = cmd.item.cnt;
          id_nxt  = cmd.item.id;
        end
      end
      OP_SHIFT2: begin
        vld_nxt = right2.vld;
        cnt_nxt = right2.cnt;
        id_nxt  = right2.id;
      end
      OP_CLR: vld_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    id_r  <= id_nxt;
  end

  assign q = '{vld: vld_r, cnt: cnt_r, id: id_r};

endmodule
`default_nettype wire

/* hdl/hcb_chain.sv */
// Row of list cells kept sorted by count; exposes the two head entries.
// Depends on hcb_pkg and hcb_cell.
`default_nettype none
module hcb_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  hcb_pkg::chain_cmd_t cmd,
  output hcb_pkg::ent_t       head0,
  output hcb_pkg::ent_t       head1
);
  import hcb_pkg::*;

  localparam ent_t EMPTY = '{vld: 1'b0, cnt: '0, id: '0};

  ent_t ents [NUM_SYMBOLS];
  logic take [NUM_SYMBOLS];

  for (genvar i = 0; i < NUM_SYMBOLS; i++) begin : g_cell
    ent_t left_e, right_e;
    logic tin;
    if (i == 0) begin : g_first
      assign left_e = EMPTY;
      assign tin    = 1'b0;
    end else begin : g_mid
      assign left_e = ents[i-1];
      assign tin    = take[i-1];
    end
    if (i + 2 < NUM_SYMBOLS) begin : g_r2
      assign right_e = ents[i+2];
    end else begin : g_end
      assign right_e = EMPTY;
    end
    hcb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .left     (left_e),
      .right2   (right_e),
      .take_in  (tin),
      .take_out (take[i]),
      .q        (ents[i])
    );
  end

  assign head0 = ents[0];
  assign head1 = ents[1];

endmodule
`default_nettype wire

/* hdl/huffman_code_builder.sv */
// Huffman code builder top: histogram store, build sequencer, code tables, result register.
// Depends on hcb_pkg, hcb_in_if, hcb_out_if, hcb_chain.
//
//   port    | dir | carries
//   in_ch   | in  | kind, data_byte, query_symbol (count / build / query / clear)
//   out_ch  | out | symbol, symbol_count, code_length, code_bits, build_done
//
// Count: accept a byte, read its histogram entry, write it back. Clear: applied on acceptance.
// Query: histogram and code table read, plus any wait for the result register.
// Build: sorted insertion of all symbols, then merges in the cell row (pop two, insert sum),
// then a code walk per internal node (read, two children; one write port per table).
// Reset is synchronous; the histogram and row use valid flags, so no sweep runs.
// A full result register stalls only items that produce a result.
`default_nettype none
module huffman_code_builder (
  input logic      clk,
  input logic      rst_n,
  hcb_in_if.sink   in_ch,
  hcb_out_if.source out_ch
);
  import hcb_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CNT_RD = 4'd1;
  localparam logic [3:0] ST_CNT_WR = 4'd2;
  localparam logic [3:0] ST_Q_RD   = 4'd3;
  localparam logic [3:0] ST_SORT   = 4'd4;
  localparam logic [3:0] ST_POP    = 4'd5;
  localparam logic [3:0] ST_INS    = 4'd6;
  localparam logic [3:0] ST_WRD    = 4'd7;
  localparam logic [3:0] ST_W0     = 4'd8;
  localparam logic [3:0] ST_W1     = 4'd9;
  localparam logic [3:0] ST_FIN    = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [NUM_SYMBOLS-1:0] hv_r, hv_nxt;
  logic              codes_valid_r, codes_valid_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [LIST_W-1:0] cnt_r, cnt_nxt;
  logic [LIST_W-1:0] len_r, len_nxt;
  logic [ID_W-1:0]   next_r, next_nxt;
  logic [ID_W-1:0]   p_r, p_nxt;
  logic              root_r, root_nxt;
  logic [ID_W-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic [NCNT_W-1:0] sum_r, sum_nxt;

  // memories
  logic [CNT_W-1:0]       hist_mem [NUM_SYMBOLS];
  logic [LEN_W-1:0]       clen_mem [NUM_SYMBOLS];
  logic [BITS_W-1:0]      cbits_mem [NUM_SYMBOLS];
  logic [2*ID_W-1:0]      kid_mem  [NUM_SYMBOLS];
  logic [LEN_W+BITS_W-1:0] scr_mem [NUM_SYMBOLS];

  logic [CNT_W-1:0]        hist_rd;
  logic [LEN_W-1:0]        clen_rd;
  logic [BITS_W-1:0]       cbits_rd;
  logic [2*ID_W-1:0]       kid_rd;
  logic [LEN_W+BITS_W-1:0] scr_rd;

  logic              hist_re, hist_we;
  logic [SYM_W-1:0]  hist_ra, hist_wa;
  logic [CNT_W-1:0]  hist_wd;
  logic              code_re, code_we;
  logic [SYM_W-1:0]  code_wa;
  logic [LEN_W-1:0]  clen_wd;
  logic [BITS_W-1:0] cbits_wd;
  logic              kid_we, scr_we, walk_re;
  logic [LEN_W+BITS_W-1:0] scr_wd;

  chain_cmd_t        cmd;
  ent_t              head0, head1;

  logic              out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]  o_sym_r, o_sym_nxt;
  logic [CNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic [LEN_W-1:0]  o_len_r, o_len_nxt;
  logic [BITS_W-1:0] o_bits_r, o_bits_nxt;
  logic              o_done_r, o_done_nxt;

  logic              in_xfer, out_free;
  logic [CNT_W-1:0]  cur_cnt;
  logic [LEN_W-1:0]  par_len, kid_len;
  logic [BITS_W-1:0] par_bits, kid_bits;
  logic [ID_W-1:0]   kid_id;
  logic              kid_bit;

  hcb_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .head0 (head0),
    .head1 (head1)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign cur_cnt  = hv_r[sym_r] ? hist_rd : '0;
  assign par_len  = root_r ? '0 : scr_rd[LEN_W+BITS_W-1:BITS_W];
  assign par_bits = root_r ? '0 : scr_rd[BITS_W-1:0];
  assign kid_bit  = (state_r == ST_W1);
  assign kid_id   = kid_bit ? kid_rd[ID_W-1:0] : kid_rd[2*ID_W-1:ID_W];
  assign kid_len  = (par_len < MAX_LEN) ? par_len + LEN_W'(1) : MAX_LEN;
  assign kid_bits = {par_bits[BITS_W-2:0], kid_bit};

  always_comb begin
    state_nxt       = state_r;
    hv_nxt          = hv_r;
    codes_valid_nxt = codes_valid_r;
    sym_nxt         = sym_r;
    cnt_nxt         = cnt_r;
    len_nxt         = len_r;
    next_nxt        = next_r;
    p_nxt           = p_r;
    root_nxt        = root_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    sum_nxt         = sum_r;
    hist_re = 1'b0; hist_ra = sym_r;
    hist_we = 1'b0; hist_wa = sym_r; hist_wd = cur_cnt + CNT_W'(1);
    code_re = 1'b0;
    code_we = 1'b0; code_wa = kid_id[SYM_W-1:0]; clen_wd = kid_len; cbits_wd = kid_bits;
    kid_we  = 1'b0;
    scr_we  = 1'b0; scr_wd = {kid_len, kid_bits};
    walk_re = 1'b0;
    cmd     = '{op: OP_HOLD, item: '{vld: 1'b1, cnt: sum_r, id: next_r}};
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_sym_nxt  = o_sym_r;
    o_cnt_nxt  = o_cnt_r;
    o_len_nxt  = o_len_r;
    o_bits_nxt = o_bits_r;
    o_done_nxt = o_done_r;

    unique case (state_r) inside
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_ch.kind)
            KIND_COUNT: begin
              sym_nxt         = in_ch.data_byte;
              hist_re         = 1'b1;
              hist_ra         = in_ch.data_byte;
              codes_valid_nxt = 1'b0;
              state_nxt       = ST_CNT_RD;
            end
            KIND_BUILD: begin
              cmd.op    = OP_CLR;
              cnt_nxt   = '0;
              len_nxt   = '0;
              next_nxt  = ID_W'(NUM_SYMBOLS);
              state_nxt = ST_SORT;
            end
            KIND_QUERY: begin
              sym_nxt   = in_ch.query_symbol;
              hist_re   = 1'b1;
              hist_ra   = in_ch.query_symbol;
              code_re   = 1'b1;
              state_nxt = ST_Q_RD;
            end
            default: begin
              hv_nxt          = '0;
              codes_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_CNT_RD: state_nxt = ST_CNT_WR;
      ST_CNT_WR: begin
        // hold a saturated count
        if (cur_cnt != '1) begin
          hist_we       = 1'b1;
          hv_nxt[sym_r] = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_Q_RD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_sym_nxt     = sym_r;
          o_cnt_nxt     = cur_cnt;
          o_len_nxt     = codes_valid_r ? clen_rd : '0;
          o_bits_nxt    = codes_valid_r ? cbits_rd : '0;
          o_done_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SORT: begin
        // read symbol cnt_r while inserting the one read last cycle
        if (!cnt_r[LIST_W-1]) begin
          hist_re  = 1'b1;
          hist_ra  = cnt_r[SYM_W-1:0];
          code_we  = 1'b1;
          code_wa  = cnt_r[SYM_W-1:0];
          clen_wd  = '0;
          cbits_wd = '0;
          sym_nxt  = cnt_r[SYM_W-1:0];
          cnt_nxt  = cnt_r + LIST_W'(1);
        end else begin
          state_nxt = ST_POP;
        end
        if (cnt_r != '0 && cur_cnt != '0) begin
          cmd.op       = OP_INS;
          cmd.item.cnt = NCNT_W'(cur_cnt);
          cmd.item.id  = {1'b0, sym_r};
          len_nxt      = len_r + LIST_W'(1);
        end
      end
      ST_POP: begin
        if (len_r >= LIST_W'(2)) begin
          cmd.op    = OP_SHIFT2;
          a_nxt     = head0.id;
          b_nxt     = head1.id;
          sum_nxt   = head0.cnt + head1.cnt;
          len_nxt   = len_r - LIST_W'(2);
          state_nxt = ST_INS;
        end else if (next_r[SYM_W-1:0] != '0) begin
          p_nxt     = next_r - ID_W'(1);
          root_nxt  = 1'b1;
          state_nxt = ST_WRD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_INS: begin
        cmd.op    = OP_INS;
        kid_we    = 1'b1;
        next_nxt  = next_r + ID_W'(1);
        len_nxt   = len_r + LIST_W'(1);
        state_nxt = ST_POP;
      end
      ST_WRD: begin
        walk_re   = 1'b1;
        state_nxt = ST_W0;
      end
      ST_W0, ST_W1: begin
        if (kid_id[ID_W-1]) begin
          scr_we = 1'b1;
        end else begin
          code_we = 1'b1;
        end
        if (state_r == ST_W0) begin
          state_nxt = ST_W1;
        end else begin
          root_nxt = 1'b0;
          if (p_r[SYM_W-1:0] == '0) begin
            state_nxt = ST_FIN;
          end else begin
            p_nxt     = p_r - ID_W'(1);
            state_nxt = ST_WRD;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          o_sym_nxt       = '0;
          o_cnt_nxt       = '0;
          o_len_nxt       = '0;
          o_bits_nxt      = '0;
          o_done_nxt      = 1'b1;
          codes_valid_nxt = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      hv_r          <= '0;
      codes_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      cnt_r         <= '0;
      len_r         <= '0;
      next_r        <= ID_W'(NUM_SYMBOLS);
      p_r           <= '0;
      root_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      hv_r          <= hv_nxt;
      codes_valid_r <= codes_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      cnt_r         <= cnt_nxt;
      len_r         <= len_nxt;
      next_r        <= next_nxt;
      p_r           <= p_nxt;
      root_r        <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r    <= sym_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    sum_r    <= sum_nxt;
    o_sym_r  <= o_sym_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_len_r  <= o_len_nxt;
    o_bits_r <= o_bits_nxt;
    o_done_r <= o_done_nxt;
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    if (hist_re) hist_rd <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (code_we) begin
      clen_mem[code_wa]  <= clen_wd;
      cbits_mem[code_wa] <= cbits_wd;
    end
    if (code_re) begin
      clen_rd  <= clen_mem[sym_nxt];
      cbits_rd <= cbits_mem[sym_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (kid_we) kid_mem[next_r[SYM_W-1:0]] <= {a_r, b_r};
    if (walk_re) kid_rd <= kid_mem[p_r[SYM_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[kid_id[SYM_W-1:0]] <= scr_wd;
    if (walk_re) scr_rd <= scr_mem[p_r[SYM_W-1:0]];
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.symbol       = o_sym_r;
  assign out_ch.symbol_count = o_cnt_r;
  assign out_ch.code_length  = o_len_r;
  assign out_ch.code_bits    = o_bits_r;
  assign out_ch.build_done   = o_done_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LIST_W'(NUM_SYMBOLS))
    else $error("node list length beyond row size");

  a_pop_heads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP && len_r >= LIST_W'(2)) |-> (head0.vld && head1.vld))
    else $error("merge pops an empty cell");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (head0.vld && head1.vld) |-> (head0.cnt <= head1.cnt))
    else $error("node list head out of order");

  a_build_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (codes_valid_r && out_valid_r && o_done_r))
    else $error("build result without valid codes");

endmodule
`default_nettype wire
